@@ sv/seven_point_stencil_1d_defines.svh @@
// ----------------------------------------------------------------------------
// seven_point_stencil_1d_defines
// assertion macros shared by the stencil checker
// ----------------------------------------------------------------------------
`ifndef SEVEN_POINT_STENCIL_1D_DEFINES_SVH
`define SEVEN_POINT_STENCIL_1D_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_pkg
// shared constants and control bundle of the 1d stencil filter
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int HALF_WIDTH_DEF  = 3;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COEF_BITS       = 16;
	localparam int FRAC_BITS       = 15;

	typedef struct packed {
		logic valid;
		logic last;
	} sps_ctl_t;

endpackage

@@ sv/sps_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_window
// sample history, frame counter and end-of-frame flush sequencer
// ----------------------------------------------------------------------------
module sps_window #(
	parameter int HALF_WIDTH  = sps_pkg::HALF_WIDTH_DEF,
	parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic                          take,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          frame_end,
	output logic                          busy,
	output sps_pkg::sps_ctl_t             issue,
	output logic signed [SAMPLE_BITS-1:0] taps [2*HALF_WIDTH+1]
);
	import sps_pkg::*;

	localparam int WIN_LEN  = 2 * HALF_WIDTH;
	localparam int NUM_TAPS = WIN_LEN + 1;
	localparam int CNT_BITS = $clog2(HALF_WIDTH + 1);

	logic signed [SAMPLE_BITS-1:0] window_q [WIN_LEN];
	logic signed [SAMPLE_BITS-1:0] flbuf_q  [NUM_TAPS];
	logic        [CNT_BITS-1:0]    seen_q;
	logic        [CNT_BITS-1:0]    left_q;

	logic signed [SAMPLE_BITS-1:0] cur     [NUM_TAPS];
	logic signed [SAMPLE_BITS-1:0] shifted [NUM_TAPS];
	logic        [CNT_BITS-1:0]    seen_nx;
	logic                          at_full;

	assign at_full = (seen_q == CNT_BITS'(HALF_WIDTH));
	assign seen_nx = at_full ? seen_q : seen_q + CNT_BITS'(1);
	assign busy    = (left_q != '0);

	always_comb begin
		for (int i = 0; i < WIN_LEN; i++) begin
			cur[i] = window_q[i];
		end
		cur[WIN_LEN] = sample;
		// first flush window: shifted left by HALF_WIDTH+1-seen_nx, zeros behind
		for (int i = 0; i < NUM_TAPS; i++) begin
			shifted[i] = '0;
			for (int s = 1; s <= HALF_WIDTH; s++) begin
				if (seen_nx == CNT_BITS'(HALF_WIDTH + 1 - s) && i + s <= WIN_LEN) begin
					shifted[i] = cur[i+s];
				end
			end
		end
	end

	always_comb begin
		if (busy) begin
			taps        = flbuf_q;
			issue.valid = 1'b1;
			issue.last  = (left_q == CNT_BITS'(1));
		end else begin
			taps        = cur;
			issue.valid = take && at_full;
			issue.last  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_LEN; i++) begin
				window_q[i] <= '0;
			end
			seen_q <= '0;
			left_q <= '0;
		end else if (adv) begin
			if (busy) begin
				left_q <= left_q - CNT_BITS'(1);
			end else if (take) begin
				if (frame_end) begin
					for (int i = 0; i < WIN_LEN; i++) begin
						window_q[i] <= '0;
					end
					seen_q <= '0;
					left_q <= seen_nx;
				end else begin
					for (int i = 0; i < WIN_LEN; i++) begin
						window_q[i] <= cur[i+1];
					end
					seen_q <= seen_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (busy) begin
				for (int i = 0; i < WIN_LEN; i++) begin
					flbuf_q[i] <= flbuf_q[i+1];
				end
				flbuf_q[WIN_LEN] <= '0;
			end else if (take && frame_end) begin
				flbuf_q <= shifted;
			end
		end
	end

endmodule

@@ sv/sps_taps.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_taps
// tap multipliers, adder, rounding and saturation pipeline
// ----------------------------------------------------------------------------
module sps_taps #(
	parameter int HALF_WIDTH  = sps_pkg::HALF_WIDTH_DEF,
	parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  sps_pkg::sps_ctl_t                      issue,
	input  logic signed [SAMPLE_BITS-1:0]          taps [2*HALF_WIDTH+1],
	input  logic signed [sps_pkg::COEF_BITS-1:0]   coef [2*HALF_WIDTH+1],
	output sps_pkg::sps_ctl_t                      res,
	output logic signed [SAMPLE_BITS-1:0]          value
);
	import sps_pkg::*;

	localparam int NUM_TAPS  = 2 * HALF_WIDTH + 1;
	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	localparam int SUM_BITS  = PROD_BITS + $clog2(NUM_TAPS);
	localparam int Q_BITS    = SUM_BITS - FRAC_BITS;

	localparam logic signed [SUM_BITS-1:0] HALF_LSB = SUM_BITS'(1) << (FRAC_BITS - 1);
	localparam logic signed [Q_BITS-1:0]   Q_HI =
		{{(Q_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [Q_BITS-1:0]   Q_LO =
		{{(Q_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [PROD_BITS-1:0] prod_s1 [NUM_TAPS];
	sps_ctl_t                    ctl_s1;
	logic signed [SUM_BITS-1:0]  sum_s2;
	sps_ctl_t                    ctl_s2;
	sps_ctl_t                    res_q;
	logic signed [SAMPLE_BITS-1:0] value_q;

	logic signed [SUM_BITS-1:0]  sum_d;
	logic signed [SUM_BITS-1:0]  rounded;
	logic signed [Q_BITS-1:0]    q;
	logic signed [SAMPLE_BITS-1:0] sat;

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NUM_TAPS; i++) begin
			sum_d = sum_d + SUM_BITS'(prod_s1[i]);
		end
	end

	// round half up, then clip to the sample range
	always_comb begin
		rounded = sum_s2 + HALF_LSB;
		q       = rounded[SUM_BITS-1:FRAC_BITS];
		if (q > Q_HI) begin
			sat = Q_HI[SAMPLE_BITS-1:0];
		end else if (q < Q_LO) begin
			sat = Q_LO[SAMPLE_BITS-1:0];
		end else begin
			sat = q[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				prod_s1[i] <= PROD_BITS'(taps[i]) * PROD_BITS'(coef[i]);
			end
			sum_s2  <= sum_d;
			value_q <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			res_q  <= '0;
		end else if (adv) begin
			ctl_s1 <= issue;
			ctl_s2 <= ctl_s1;
			res_q  <= ctl_s2;
		end
	end

	assign res   = res_q;
	assign value = value_q;

endmodule

@@ sv/seven_point_stencil_1d.sv @@
`timescale 1ns / 1ps
// a result passes the product, sum and output registers (prod_s1, sum_s2, value_q) after
// acceptance of the request that completes its window; a held result freezes them all
// throughput: one sample per cycle while no result is held; a frame end adds up to HALF_WIDTH
// flush results, during which sample_stall is high, since one result leaves the issue stage per cycle
// reset: clears coefficients, sample history, frame count and all valid flags
// ----------------------------------------------------------------------------
// seven_point_stencil_1d
// centered 7-tap fir over framed samples with zero halo, q1.15 weights
// ----------------------------------------------------------------------------
module seven_point_stencil_1d #(
	parameter int HALF_WIDTH  = sps_pkg::HALF_WIDTH_DEF,
	parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     sample_valid,
	output logic                                     sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]            sample,
	input  logic                                     frame_end,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic signed [SAMPLE_BITS-1:0]            value,
	output logic                                     last,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [$clog2(2*HALF_WIDTH+1)-1:0]        cfg_index,
	input  logic [sps_pkg::COEF_BITS-1:0]            cfg_data
);
	import sps_pkg::*;

	localparam int NUM_TAPS = 2 * HALF_WIDTH + 1;
	localparam int IDX_BITS = $clog2(NUM_TAPS);

	logic signed [COEF_BITS-1:0]   coef_q [NUM_TAPS];
	logic signed [SAMPLE_BITS-1:0] taps   [NUM_TAPS];
	sps_ctl_t                      issue;
	sps_ctl_t                      res;
	logic                          busy;
	logic                          adv;
	logic                          take;

	// whole pipeline moves unless a finished result is held by the sink
	assign adv          = !(res.valid && result_stall);
	assign sample_stall = !adv || busy;
	assign take         = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = res.valid;
	assign last         = res.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NUM_TAPS; i++) begin
				if (cfg_index == IDX_BITS'(i)) begin
					coef_q[i] <= cfg_data;
				end
			end
		end
	end

	sps_window #(
		.HALF_WIDTH (HALF_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (take),
		.sample   (sample),
		.frame_end(frame_end),
		.busy     (busy),
		.issue    (issue),
		.taps     (taps)
	);

	sps_taps #(
		.HALF_WIDTH (HALF_WIDTH),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_taps (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.issue (issue),
		.taps  (taps),
		.coef  (coef_q),
		.res   (res),
		.value (value)
	);

endmodule

@@ sv/sps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sps_checker
// port-level checks of the stencil filter, bound to the top level
// ----------------------------------------------------------------------------
`include "seven_point_stencil_1d_defines.svh"

module sps_checker #(
	parameter int SAMPLE_BITS = sps_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   sample_valid,
	input logic                   sample_stall,
	input logic                   frame_end,
	input logic                   result_valid,
	input logic                   result_stall,
	input logic [SAMPLE_BITS-1:0] value,
	input logic                   last
);
	import sps_pkg::*;

	`SPS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid && $stable(value) && $stable(last), "stalled result changed")

	// a held result freezes the pipeline, so no request may enter
	`SPS_ASSERT_NOW(a_backpressure, result_valid && result_stall, sample_stall, "request taken while output blocked")

	// a frame end always leaves at least one flush result to issue
	`SPS_ASSERT_NEXT(a_flush_blocks, sample_valid && !sample_stall && frame_end, sample_stall, "request taken during frame flush")

endmodule

bind seven_point_stencil_1d sps_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sps_checker (.*);
